### src/ielr_pkg.sv
`default_nettype none

package ielr_pkg;

  localparam int SCREEN_WIDTH_DEF = 1024;
  localparam int SCREEN_HEIGHT_DEF = 768;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam longint unsigned COS_Q25 = 64'd29058987;
  localparam longint unsigned SIN_Q25 = 64'd16777223;

  localparam logic [7:0] ZOOM_RESET = 8'd20;

  localparam logic signed [15:0] COORD_MIN = 16'sh8000;
  localparam logic signed [15:0] COORD_MAX = 16'sh7FFF;
  localparam logic signed [15:0] X_MAX = 16'sh7FFE;

  localparam logic signed [1:0] DIR_UP = 2'sb01;
  localparam logic signed [1:0] DIR_DOWN = 2'sb11;
  localparam logic signed [1:0] DIR_FLAT = 2'sb00;

  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    KIND_RIGHT = 1'b0,
    KIND_ABOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    REG_ZOOM  = 2'd0,
    REG_PAN_X = 2'd1,
    REG_PAN_Y = 2'd2
  } reg_index_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [10:0] diag_d;
    logic [10:0]        diag_s;
    logic signed [15:0] h0;
    logic signed [15:0] h1;
    kind_t              kind;
  } entry_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] end_x;
    logic [16:0]        span_x;
    logic [16:0]        err_inc;
    logic signed [1:0]  y_dir;
  } load_t;

  function automatic int trig_q(input longint unsigned q25, input int frac);
    return int'(((q25 >> (24 - frac)) + 64'd1) >> 1);
  endfunction

endpackage

`default_nettype wire

### src/ielr_front.sv
`default_nettype none

module ielr_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               command,
  input  wire logic [9:0]         grid_col,
  input  wire logic [9:0]         grid_row,
  input  wire logic signed [15:0] height_here,
  input  wire logic signed [15:0] height_neighbor,
  input  wire logic               neighbor_kind,
  input  wire logic               q_full,
  output logic                    push,
  output ielr_pkg::entry_t        entry
);
  import ielr_pkg::*;

  assign in_ready = !q_full;
  assign push = in_valid && !q_full;

  always_comb begin
    entry.cmd = cmd_t'(command);
    entry.diag_d = $signed({1'b0, grid_col}) - $signed({1'b0, grid_row});
    entry.diag_s = {1'b0, grid_col} + {1'b0, grid_row};
    entry.h0 = height_here;
    entry.h1 = height_neighbor;
    entry.kind = kind_t'(neighbor_kind);
  end

endmodule

`default_nettype wire

### src/ielr_queue.sv
`default_nettype none

module ielr_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ielr_pkg::entry_t  push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   valid,
  output ielr_pkg::entry_t       head
);
  import ielr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/ielr_proj.sv
`default_nettype none

module ielr_proj #(
  parameter int FRAC_BITS = ielr_pkg::FRAC_BITS_DEF,
  parameter int SCREEN_WIDTH = ielr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ielr_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire ielr_pkg::entry_t   entry,
  input  wire logic [7:0]         zoom,
  input  wire logic signed [10:0] pan_x,
  input  wire logic signed [10:0] pan_y,
  output logic                    busy,
  output ielr_pkg::load_t         load
);
  import ielr_pkg::*;

  localparam int A_W = 13;
  localparam int B_W = 17;
  localparam int M1_W = 22;
  localparam int M2_W = 26;
  localparam int K_W = FRAC_BITS + 2;
  localparam int VW = FRAC_BITS + 28;
  localparam int TW = VW - FRAC_BITS;

  localparam logic signed [K_W-1:0] COS_K = K_W'(trig_q(COS_Q25, FRAC_BITS));
  localparam logic signed [K_W-1:0] SIN_K = K_W'(trig_q(SIN_Q25, FRAC_BITS));
  localparam logic signed [VW-1:0] CENTER_X = VW'(SCREEN_WIDTH / 2) <<< FRAC_BITS;
  localparam logic signed [VW-1:0] CENTER_Y = VW'(SCREEN_HEIGHT / 2) <<< FRAC_BITS;
  localparam logic signed [VW-1:0] BIAS = VW'((longint'(1) << FRAC_BITS) - 1);
  localparam logic signed [TW-1:0] T_MIN = TW'(COORD_MIN);
  localparam logic signed [TW-1:0] T_X_HI = TW'(X_MAX);
  localparam logic signed [TW-1:0] T_Y_HI = TW'(COORD_MAX);

  typedef enum logic [1:0] {
    PT_X0 = 2'd0,
    PT_X1 = 2'd1,
    PT_Y0 = 2'd2,
    PT_Y1 = 2'd3
  } pt_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_SWAP  = 5'b01000,
    S_LOAD  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  pt_t cnt;

  logic signed [10:0] op_d;
  logic [10:0] op_s;
  logic signed [15:0] op_h0;
  logic signed [15:0] op_h1;
  kind_t op_kind;

  logic signed [A_W-1:0] iss_a;
  logic signed [B_W-1:0] iss_b;
  logic signed [A_W-1:0] s_ext;
  logic signed [8:0] zoom_s;

  logic a_valid;
  pt_t a_pt;
  logic signed [M1_W-1:0] a_m1;
  logic signed [M2_W-1:0] a_m2;
  logic signed [K_W-1:0] a_k;
  logic signed [VW-1:0] a_center;

  logic b_valid;
  pt_t b_pt;
  logic signed [VW-1:0] b_v;
  logic signed [VW-1:0] b_sum;

  logic c_valid;
  pt_t c_pt;
  logic signed [TW-1:0] c_t;
  logic signed [TW-1:0] c_hi;
  logic signed [15:0] c_coord;

  logic signed [15:0] rx0, rx1, ry0, ry1;
  logic signed [15:0] sx0, sx1, sy0, sy1;
  logic [16:0] dx_w;
  logic [16:0] yd_w;
  logic [16:0] dy_w;

  assign busy = (state != S_IDLE);
  assign zoom_s = $signed({1'b0, zoom});
  assign s_ext = $signed({2'b00, op_s});

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_ISSUE;
      S_ISSUE: if (cnt == PT_Y1) state_next = S_WAIT;
      S_WAIT: if (c_valid && c_pt == PT_Y1) state_next = S_SWAP;
      S_SWAP: state_next = S_LOAD;
      S_LOAD: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= PT_X0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ISSUE) begin
        cnt <= pt_t'(cnt + 2'd1);
      end else begin
        cnt <= PT_X0;
      end
      a_valid <= (state == S_ISSUE);
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_d <= entry.diag_d;
      op_s <= entry.diag_s;
      op_h0 <= entry.h0;
      op_h1 <= entry.h1;
      op_kind <= entry.kind;
    end
  end

  always_comb begin
    iss_a = '0;
    iss_b = '0;
    case (cnt)
      PT_X0: begin
        iss_a = A_W'(op_d);
        iss_b = B_W'(pan_x);
      end
      PT_X1: begin
        iss_a = A_W'(op_d) + 13'sd1;
        iss_b = B_W'(pan_x);
      end
      PT_Y0: begin
        iss_a = s_ext;
        iss_b = B_W'(pan_y) - B_W'(op_h0);
      end
      PT_Y1: begin
        iss_a = (op_kind == KIND_ABOVE) ? s_ext - 13'sd1 : s_ext + 13'sd1;
        iss_b = B_W'(pan_y) - B_W'(op_h1);
      end
      default: begin
        iss_a = '0;
        iss_b = '0;
      end
    endcase
  end

  always_comb begin
    if (a_pt == PT_Y0 || a_pt == PT_Y1) begin
      a_k = SIN_K;
      a_center = CENTER_Y;
    end else begin
      a_k = COS_K;
      a_center = CENTER_X;
    end
  end

  assign b_sum = b_v + (b_v[VW-1] ? BIAS : '0);

  always_comb begin
    c_hi = (c_pt == PT_Y0 || c_pt == PT_Y1) ? T_Y_HI : T_X_HI;
    if (c_t < T_MIN) begin
      c_coord = COORD_MIN;
    end else if (c_t > c_hi) begin
      c_coord = c_hi[15:0];
    end else begin
      c_coord = c_t[15:0];
    end
  end

  always_ff @(posedge clk) begin
    a_pt <= cnt;
    a_m1 <= M1_W'(zoom_s) * M1_W'(iss_a);
    a_m2 <= M2_W'(zoom_s) * M2_W'(iss_b);
    b_pt <= a_pt;
    b_v <= VW'(a_m1) * VW'(a_k) + (VW'(a_m2) <<< FRAC_BITS) + a_center;
    c_pt <= b_pt;
    c_t <= b_sum[VW-1:FRAC_BITS];
    if (c_valid) begin
      case (c_pt)
        PT_X0: rx0 <= c_coord;
        PT_X1: rx1 <= c_coord;
        PT_Y0: ry0 <= c_coord;
        PT_Y1: ry1 <= c_coord;
        default: rx0 <= c_coord;
      endcase
    end
    if (state == S_SWAP) begin
      if (rx0 > rx1) begin
        sx0 <= rx1;
        sx1 <= rx0;
        sy0 <= ry1;
        sy1 <= ry0;
      end else begin
        sx0 <= rx0;
        sx1 <= rx1;
        sy0 <= ry0;
        sy1 <= ry1;
      end
    end
  end

  assign dx_w = {sx1[15], sx1} - {sx0[15], sx0};
  assign yd_w = {sy1[15], sy1} - {sy0[15], sy0};
  assign dy_w = (sy1 > sy0) ? yd_w : 17'd0 - yd_w;

  always_comb begin
    load.valid = (state == S_LOAD);
    load.x0 = sx0;
    load.y0 = sy0;
    load.end_x = sx1;
    load.span_x = dx_w + 17'd1;
    load.err_inc = dy_w + 17'd1;
    if (sy1 > sy0) begin
      load.y_dir = DIR_UP;
    end else if (sy1 < sy0) begin
      load.y_dir = DIR_DOWN;
    end else begin
      load.y_dir = DIR_FLAT;
    end
  end

endmodule

`default_nettype wire

### src/ielr_walk.sv
`default_nettype none

module ielr_walk #(
  parameter int SCREEN_WIDTH = ielr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ielr_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ielr_pkg::load_t    load,
  input  wire logic               step,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic signed [15:0]      pixel_x,
  output logic signed [15:0]      pixel_y,
  output logic                    visible,
  output logic                    last,
  output logic                    out_free,
  output logic                    busy
);
  import ielr_pkg::*;

  localparam logic signed [15:0] W_LIM = 16'(SCREEN_WIDTH);
  localparam logic signed [15:0] H_LIM = 16'(SCREEN_HEIGHT);

  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic signed [15:0] end_x;
  logic [17:0] err_acc;
  logic [16:0] span_x;
  logic [16:0] err_inc;
  logic signed [1:0] y_dir;

  logic fire;
  logic ystep;
  logic fin;
  logic vis;
  logic signed [15:0] end_next;
  logic signed [15:0] y_next;
  logic signed [15:0] x_next;

  assign out_free = !out_valid || out_ready;
  assign fire = step && busy;
  assign ystep = err_acc >= {1'b0, span_x};
  assign end_next = end_x + 16'sd1;
  assign fin = !ystep && (cur_x == end_next);
  assign vis = (cur_x > 16'sd0) && (cur_x < W_LIM) && (cur_y > 16'sd0) && (cur_y < H_LIM);
  assign x_next = (cur_x == COORD_MAX) ? cur_x : cur_x + 16'sd1;

  always_comb begin
    y_next = cur_y;
    if (y_dir == DIR_UP && cur_y != COORD_MAX) begin
      y_next = cur_y + 16'sd1;
    end else if (y_dir == DIR_DOWN && cur_y != COORD_MIN) begin
      y_next = cur_y - 16'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load.valid) begin
        busy <= 1'b1;
      end else if (fire && fin) begin
        busy <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      cur_x <= load.x0;
      cur_y <= load.y0;
      end_x <= load.end_x;
      span_x <= load.span_x;
      err_inc <= load.err_inc;
      y_dir <= load.y_dir;
      err_acc <= '0;
    end else if (fire) begin
      if (ystep) begin
        cur_y <= y_next;
        err_acc <= err_acc - {1'b0, span_x};
      end else begin
        err_acc <= err_acc + {1'b0, err_inc};
        if (!fin) begin
          cur_x <= x_next;
        end
      end
    end
    if (fire) begin
      pixel_x <= cur_x;
      pixel_y <= cur_y;
      visible <= vis;
      last <= fin;
    end
  end

endmodule

`default_nettype wire

### src/isometric_edge_line_rasterizer.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    command, grid_col, grid_row, heights, kind
// out      output     out_valid / out_ready  pixel_x, pixel_y, visible, last
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data (zoom, pan_x, pan_y)
//
// Requests pass through a four-entry queue. Step requests leave its head at one per cycle
// while the output is free and no start is projecting, and each pixel is registered and
// appears in the cycle after. A start request runs through the shared projection pipeline:
// four points issued one per cycle, then an endpoint swap and a load of the walker.
// Reset is synchronous; it empties the queue, idles the walker and sets zoom to 20.
// A stalled output holds the walker, and the queue keeps taking requests until full.
`default_nettype none

module isometric_edge_line_rasterizer #(
  parameter int SCREEN_WIDTH = ielr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ielr_pkg::SCREEN_HEIGHT_DEF,
  parameter int FRAC_BITS = ielr_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               command,
  input  wire logic [9:0]         grid_col,
  input  wire logic [9:0]         grid_row,
  input  wire logic signed [15:0] height_here,
  input  wire logic signed [15:0] height_neighbor,
  input  wire logic               neighbor_kind,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      pixel_x,
  output logic signed [15:0]      pixel_y,
  output logic                    visible,
  output logic                    last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [10:0]        cfg_data
);
  import ielr_pkg::*;

  logic [7:0] zoom;
  logic signed [10:0] pan_x;
  logic signed [10:0] pan_y;

  logic push;
  entry_t push_entry;
  logic q_full;
  logic q_valid;
  logic q_pop;
  entry_t q_head;

  logic proj_busy;
  load_t load;
  logic start_go;
  logic step_go;
  logic out_free;
  logic walk_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom <= ZOOM_RESET;
      pan_x <= '0;
      pan_y <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ZOOM: zoom <= cfg_data[7:0];
        REG_PAN_X: pan_x <= cfg_data;
        REG_PAN_Y: pan_y <= cfg_data;
        default: zoom <= zoom;
      endcase
    end
  end

  ielr_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .grid_col        (grid_col),
    .grid_row        (grid_row),
    .height_here     (height_here),
    .height_neighbor (height_neighbor),
    .neighbor_kind   (neighbor_kind),
    .q_full          (q_full),
    .push            (push),
    .entry           (push_entry)
  );

  ielr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  assign start_go = q_valid && (q_head.cmd == CMD_START) && !proj_busy;
  assign step_go = q_valid && (q_head.cmd == CMD_STEP) && !proj_busy && out_free;
  assign q_pop = start_go || step_go;

  ielr_proj #(
    .FRAC_BITS     (FRAC_BITS),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_proj (
    .clk   (clk),
    .rst   (rst),
    .start (start_go),
    .entry (q_head),
    .zoom  (zoom),
    .pan_x (pan_x),
    .pan_y (pan_y),
    .busy  (proj_busy),
    .load  (load)
  );

  ielr_walk #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .step      (step_go),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .visible   (visible),
    .last      (last),
    .out_free  (out_free),
    .busy      (walk_busy)
  );

  a_no_step_during_projection: assert property (@(posedge clk) disable iff (rst)
    proj_busy |-> !step_go)
    else $error("step request issued while an edge start is being projected");

  a_load_arms_walker: assert property (@(posedge clk) disable iff (rst)
    load.valid |=> walk_busy)
    else $error("walker not busy after an edge load");

  a_push_fills_queue: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> q_valid)
    else $error("queue empty right after accepting a request");

endmodule

`default_nettype wire
